// File: hdl/owrs_pkg.sv
// Shared types, constants and helper functions for the 1-Wire READ ROM slave.
package owrs_pkg;

  localparam int unsigned ROM_BYTES   = 8;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned ROM_W       = 64;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned PADDR_W     = 6;
  localparam int unsigned PDATA_W     = 64;

  localparam logic [CNT_W-1:0] ROM_BYTES_CNT = CNT_W'(ROM_BYTES);
  localparam logic [CNT_W-1:0] ROM_LAST      = CNT_W'(ROM_BYTES - 1);
  localparam logic [CNT_W-1:0] BITS_PER_BYTE = CNT_W'(8);

  localparam logic [7:0] CMD_READ_ROM     = 8'h33;
  localparam logic [7:0] CMD_READ_ROM_ALT = 8'h0F;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RESET = 3'd1,
    PH_PWAIT = 3'd2,
    PH_PRES  = 3'd3,
    PH_CMD   = 3'd4,
    PH_READ  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    REG_ROM_ID        = 3'd0,
    REG_SAMPLE_DELAY  = 3'd1,
    REG_READ_RELEASE  = 3'd2,
    REG_RESET_LOW     = 3'd3,
    REG_PRESENCE_WAIT = 3'd4,
    REG_PRESENCE_LEN  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic              action;
    logic              line_level;
    logic [TIME_W-1:0] time_now;
  } owrs_in_t;

  typedef struct packed {
    logic       slave_drive;
    logic       bus_level;
    logic [2:0] phase;
  } owrs_out_t;

  typedef struct packed {
    logic [ROM_W-1:0]   rom_id;
    logic [DELAY_W-1:0] sample_delay;
    logic [DELAY_W-1:0] read_release_delay;
    logic [DELAY_W-1:0] reset_low_time;
    logic [DELAY_W-1:0] presence_wait;
    logic [DELAY_W-1:0] presence_length;
  } owrs_cfg_t;

  localparam owrs_cfg_t CFG_RESET = '{
    rom_id:             '0,
    sample_delay:       16'd60,
    read_release_delay: 16'd60,
    reset_low_time:     16'd960,
    presence_wait:      16'd60,
    presence_length:    16'd240
  };

  // Deadline a given number of ticks after now, saturating at the top of the time range.
  function automatic logic [TIME_W-1:0] later(input logic [TIME_W-1:0] now,
                                              input logic [DELAY_W-1:0] dly);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + {{(TIME_W-DELAY_W+1){1'b0}}, dly};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage

// File: hdl/owrs_core.sv
// Protocol state of the slave and the combinational update for one transaction.
module owrs_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_take,
  input  owrs_pkg::owrs_in_t  item,
  input  owrs_pkg::owrs_cfg_t cfg,
  output owrs_pkg::owrs_out_t result
);
  import owrs_pkg::*;

  phase_t             phase_r,  phase_nxt;
  logic               master_r, master_nxt;
  logic               drive_r,  drive_nxt;
  logic [CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]   byte_cnt_r, byte_cnt_nxt;
  logic [7:0]         shift_r,  shift_nxt;
  logic [TIME_W-1:0]  main_dl_r, main_dl_nxt;
  logic               main_arm_r, main_arm_nxt;
  logic [TIME_W-1:0]  rst_dl_r, rst_dl_nxt;
  logic               rst_arm_r, rst_arm_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      master_r   <= 1'b1;
      drive_r    <= 1'b1;
      bit_cnt_r  <= '0;
      byte_cnt_r <= '0;
      shift_r    <= '0;
      main_dl_r  <= '0;
      main_arm_r <= 1'b0;
      rst_dl_r   <= '0;
      rst_arm_r  <= 1'b0;
    end else if (item_take) begin
      phase_r    <= phase_nxt;
      master_r   <= master_nxt;
      drive_r    <= drive_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      shift_r    <= shift_nxt;
      main_dl_r  <= main_dl_nxt;
      main_arm_r <= main_arm_nxt;
      rst_dl_r   <= rst_dl_nxt;
      rst_arm_r  <= rst_arm_nxt;
    end
  end

  always_comb begin
    logic [CNT_W-1:0] byte_sel;
    logic [2:0]       idx;
    phase_nxt    = phase_r;
    master_nxt   = master_r;
    drive_nxt    = drive_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    main_dl_nxt  = main_dl_r;
    main_arm_nxt = main_arm_r;
    rst_dl_nxt   = rst_dl_r;
    rst_arm_nxt  = rst_arm_r;
    byte_sel     = ROM_LAST - byte_cnt_r;
    idx          = byte_sel[2:0];

    if (!item.action) begin
      if (!item.line_level && master_r) begin
        // Falling edge from the master.
        if (phase_r == PH_CMD) begin
          main_dl_nxt  = later(item.time_now, cfg.sample_delay);
          main_arm_nxt = 1'b1;
        end else if (phase_r == PH_READ) begin
          if (byte_cnt_r < ROM_BYTES_CNT) begin
            if (bit_cnt_r == '0) begin
              shift_nxt = cfg.rom_id[{idx, 3'b000} +: 8];
            end
            drive_nxt   = shift_nxt[0];
            shift_nxt   = {1'b0, shift_nxt[7:1]};
            bit_cnt_nxt = bit_cnt_r + 1'b1;
            if (bit_cnt_nxt == BITS_PER_BYTE) begin
              bit_cnt_nxt  = '0;
              byte_cnt_nxt = byte_cnt_r + 1'b1;
            end
          end else begin
            drive_nxt = 1'b1;
          end
          main_dl_nxt  = later(item.time_now, cfg.read_release_delay);
          main_arm_nxt = 1'b1;
        end
        rst_dl_nxt  = later(item.time_now, cfg.reset_low_time);
        rst_arm_nxt = 1'b1;
      end else if (item.line_level && !master_r) begin
        // Rising edge: a pending bus reset moves on to the presence wait.
        if (phase_r == PH_RESET) begin
          phase_nxt    = PH_PWAIT;
          main_dl_nxt  = later(item.time_now, cfg.presence_wait);
          main_arm_nxt = 1'b1;
        end
        rst_arm_nxt = 1'b0;
      end
      master_nxt = item.line_level;
    end else begin
      if (rst_arm_r && item.time_now >= rst_dl_r) begin
        phase_nxt   = PH_RESET;
        rst_arm_nxt = 1'b0;
      end
      if (main_arm_r && item.time_now >= main_dl_r) begin
        main_arm_nxt = 1'b0;
        case (phase_nxt)
          PH_PWAIT: begin
            drive_nxt    = 1'b0;
            phase_nxt    = PH_PRES;
            main_dl_nxt  = later(item.time_now, cfg.presence_length);
            main_arm_nxt = 1'b1;
          end
          PH_PRES: begin
            drive_nxt    = 1'b1;
            bit_cnt_nxt  = '0;
            byte_cnt_nxt = '0;
            shift_nxt    = '0;
            phase_nxt    = PH_CMD;
          end
          PH_CMD: begin
            shift_nxt   = {master_r, shift_r[7:1]};
            bit_cnt_nxt = bit_cnt_r + 1'b1;
            if (bit_cnt_nxt == BITS_PER_BYTE) begin
              if (shift_nxt == CMD_READ_ROM || shift_nxt == CMD_READ_ROM_ALT) begin
                bit_cnt_nxt  = '0;
                byte_cnt_nxt = '0;
                phase_nxt    = PH_READ;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
          end
          PH_READ: begin
            drive_nxt = 1'b1;
            if (byte_cnt_r >= ROM_BYTES_CNT) begin
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
    end

    result.slave_drive = drive_nxt;
    result.bus_level   = drive_nxt & master_nxt;
    result.phase       = phase_nxt;
  end

endmodule

// File: hdl/owrs_skid.sv
// Output register with one skid entry for the result channel.
module owrs_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  owrs_pkg::owrs_out_t push_data,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output owrs_pkg::owrs_out_t out_data
);
  import owrs_pkg::*;

  logic      main_vld_r;
  owrs_out_t main_r;
  logic      skid_vld_r;
  owrs_out_t skid_r;
  logic      pop;

  assign pop       = main_vld_r & out_ready;
  assign space     = ~skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      main_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

endmodule

// File: hdl/one_wire_rom_slave_top.sv
// Top level of the 1-Wire READ ROM slave: configuration registers, core and result buffer.
//
//   Channel  Direction  Handshake                          Payload
//   in_      input      in_valid / in_ready                owrs_in_t (action, line_level, time_now)
//   out_     output     out_valid / out_ready              owrs_out_t (slave_drive, bus_level, phase)
//   config   APB write  psel, penable, pwrite, pready      paddr, pwdata, prdata (64 bits)
//
// Every input transaction is handled in one pass of logic that yields the protocol state
// and the result; the result is registered at the accepting edge, so one transaction per
// cycle is sustained while in_ready is high, and the result is offered on the following cycle
// when the output register is free or being emptied. The path is set by the 48-bit deadline adders.
// The synchronous active-low reset returns the slave to idle with the line released
// and the default timing; one skid entry means the input stalls only once two results wait.
module one_wire_rom_slave_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  owrs_pkg::owrs_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output owrs_pkg::owrs_out_t                  out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [owrs_pkg::PADDR_W-1:0]         paddr,
  input  logic [owrs_pkg::PDATA_W-1:0]         pwdata,
  output logic [owrs_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);
  import owrs_pkg::*;

  owrs_cfg_t cfg_r;
  logic      cfg_wr;
  reg_idx_t  reg_sel;
  logic      in_take;
  owrs_out_t core_result;

  // Registers sit on eight-byte boundaries because the ROM identifier is 64 bits wide.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ROM_ID:        cfg_r.rom_id             <= pwdata;
        REG_SAMPLE_DELAY:  cfg_r.sample_delay       <= pwdata[DELAY_W-1:0];
        REG_READ_RELEASE:  cfg_r.read_release_delay <= pwdata[DELAY_W-1:0];
        REG_RESET_LOW:     cfg_r.reset_low_time     <= pwdata[DELAY_W-1:0];
        REG_PRESENCE_WAIT: cfg_r.presence_wait      <= pwdata[DELAY_W-1:0];
        REG_PRESENCE_LEN:  cfg_r.presence_length    <= pwdata[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back of the configuration; unused addresses read as zero.
  always_comb begin
    case (reg_sel)
      REG_ROM_ID:        prdata = cfg_r.rom_id;
      REG_SAMPLE_DELAY:  prdata = PDATA_W'(cfg_r.sample_delay);
      REG_READ_RELEASE:  prdata = PDATA_W'(cfg_r.read_release_delay);
      REG_RESET_LOW:     prdata = PDATA_W'(cfg_r.reset_low_time);
      REG_PRESENCE_WAIT: prdata = PDATA_W'(cfg_r.presence_wait);
      REG_PRESENCE_LEN:  prdata = PDATA_W'(cfg_r.presence_length);
      default:           prdata = '0;
    endcase
  end

  assign in_take = in_valid & in_ready;

  // The core holds the protocol state and updates it on every accepted transaction.
  owrs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_take (in_take),
    .item      (in_data),
    .cfg       (cfg_r),
    .result    (core_result)
  );

  // Results are registered here, with one spare entry to ride out a stalled consumer.
  owrs_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (core_result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The input can only be held off while a result is waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // An accepted transaction always leaves a result at the output.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid)
    else $error("accepted transaction produced no result");

  // The bus cannot read high while the slave is pulling it low.
  a_wired_and: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.slave_drive) |-> !out_data.bus_level)
    else $error("bus level high while slave drives low");

endmodule

// File: bench/one_wire_rom_slave_top_tb.sv
// Self-checking bench for the 1-Wire READ ROM slave, driven with line edges and time ticks.
module one_wire_rom_slave_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import owrs_pkg::*;

  // Kinds of input transaction: a new master level on the line, or a plain time tick.
  localparam logic ACT_LINE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // An address beyond the register map; writes there must leave every register alone.
  localparam logic [2:0] REG_SPARE = 3'd6;

  localparam logic [TIME_W-1:0] TIME_TOP = '1;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_ITEMS = 50;

  // Ways in which the result side holds off out_ready.
  typedef enum int {RX_OPEN, RX_THREE_IN_FOUR, RX_COIN, RX_BURSTY} rx_mode_t;

  // Tracks the slave's protocol state, timing registers and line levels, and holds the
  // levels that each accepted transaction should produce until the block hands them out.
  class slave_line_tracker;
    owrs_cfg_t         cfg;
    phase_t            ph;
    logic              master_lvl;
    logic              drive_lvl;
    logic [CNT_W-1:0]  bit_cnt;
    logic [CNT_W-1:0]  byte_cnt;
    logic [7:0]        shifter;
    logic [TIME_W-1:0] slot_deadline;
    logic              slot_armed;
    logic [TIME_W-1:0] low_deadline;
    logic              low_armed;
    owrs_out_t         due_levels[$];
    int                fault_count;

    function new();
      cfg           = CFG_RESET;
      ph            = PH_IDLE;
      master_lvl    = 1'b1;
      drive_lvl     = 1'b1;
      bit_cnt       = '0;
      byte_cnt      = '0;
      shifter       = '0;
      slot_deadline = '0;
      slot_armed    = 1'b0;
      low_deadline  = '0;
      low_armed     = 1'b0;
      fault_count   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_ROM_ID:        cfg.rom_id             = value[ROM_W-1:0];
        REG_SAMPLE_DELAY:  cfg.sample_delay       = value[DELAY_W-1:0];
        REG_READ_RELEASE:  cfg.read_release_delay = value[DELAY_W-1:0];
        REG_RESET_LOW:     cfg.reset_low_time     = value[DELAY_W-1:0];
        REG_PRESENCE_WAIT: cfg.presence_wait      = value[DELAY_W-1:0];
        REG_PRESENCE_LEN:  cfg.presence_length    = value[DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    // A deadline some ticks ahead, pinned to the top of the time range.
    function logic [TIME_W-1:0] deadline_after(logic [TIME_W-1:0] now,
                                               logic [DELAY_W-1:0] ticks);
      logic [TIME_W:0] sum;
      sum = {1'b0, now} + (TIME_W+1)'(ticks);
      return sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
    endfunction

    function void line_event(logic lvl, logic [TIME_W-1:0] now);
      logic [2:0] rom_byte;
      if (!lvl && master_lvl) begin
        if (ph == PH_CMD) begin
          slot_deadline = deadline_after(now, cfg.sample_delay);
          slot_armed    = 1'b1;
        end else if (ph == PH_READ) begin
          if (byte_cnt < ROM_BYTES_CNT) begin
            if (bit_cnt == '0) begin
              rom_byte = 3'(ROM_BYTES - 1) - byte_cnt[2:0];
              shifter  = cfg.rom_id[8*rom_byte +: 8];
            end
            drive_lvl = shifter[0];
            shifter   = shifter >> 1;
            bit_cnt   = bit_cnt + 1'b1;
            if (bit_cnt == BITS_PER_BYTE) begin
              bit_cnt  = '0;
              byte_cnt = byte_cnt + 1'b1;
            end
          end else begin
            drive_lvl = 1'b1;
          end
          slot_deadline = deadline_after(now, cfg.read_release_delay);
          slot_armed    = 1'b1;
        end
        low_deadline = deadline_after(now, cfg.reset_low_time);
        low_armed    = 1'b1;
      end else if (lvl && !master_lvl) begin
        if (ph == PH_RESET) begin
          ph            = PH_PWAIT;
          slot_deadline = deadline_after(now, cfg.presence_wait);
          slot_armed    = 1'b1;
        end
        low_armed = 1'b0;
      end
      master_lvl = lvl;
    endfunction

    function void tick_event(logic [TIME_W-1:0] now);
      if (low_armed && now >= low_deadline) begin
        ph        = PH_RESET;
        low_armed = 1'b0;
      end
      if (slot_armed && now >= slot_deadline) begin
        slot_armed = 1'b0;
        case (ph)
          PH_PWAIT: begin
            drive_lvl     = 1'b0;
            ph            = PH_PRES;
            slot_deadline = deadline_after(now, cfg.presence_length);
            slot_armed    = 1'b1;
          end
          PH_PRES: begin
            drive_lvl = 1'b1;
            bit_cnt   = '0;
            byte_cnt  = '0;
            shifter   = '0;
            ph        = PH_CMD;
          end
          PH_CMD: begin
            shifter = {master_lvl, shifter[7:1]};
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt == BITS_PER_BYTE) begin
              if (shifter == CMD_READ_ROM || shifter == CMD_READ_ROM_ALT) begin
                bit_cnt  = '0;
                byte_cnt = '0;
                ph       = PH_READ;
              end else begin
                ph = PH_IDLE;
              end
            end
          end
          PH_READ: begin
            drive_lvl = 1'b1;
            if (byte_cnt >= ROM_BYTES_CNT) ph = PH_IDLE;
          end
          default: ;
        endcase
      end
    endfunction

    function void note_item(owrs_in_t item);
      owrs_out_t want;
      if (item.action == ACT_LINE) line_event(item.line_level, item.time_now);
      else tick_event(item.time_now);
      want.slave_drive = drive_lvl;
      want.bus_level   = drive_lvl & master_lvl;
      want.phase       = ph;
      due_levels.push_back(want);
    endfunction

    function void compare_field(string name, logic [2:0] want, logic [2:0] got);
      if (want !== got) begin
        fault_count++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_levels(owrs_out_t got);
      owrs_out_t want;
      if (due_levels.size() == 0) begin
        fault_count++;
        $display("%0t: result expected none, got %p", $time, got);
        return;
      end
      want = due_levels.pop_front();
      compare_field("slave_drive", 3'(want.slave_drive), 3'(got.slave_drive));
      compare_field("bus_level", 3'(want.bus_level), 3'(got.bus_level));
      compare_field("phase", want.phase, got.phase);
    endfunction

    function int pending();
      return due_levels.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  owrs_in_t           in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  owrs_out_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  slave_line_tracker tracker = new();

  // The tick count that the stimulus has reached, the number of input transactions
  // accepted so far, and what is left of the sender's current burst.
  logic [TIME_W-1:0] stamp;
  int                sent_items;
  int                burst_left;

  int unsigned cycles = 0;
  int          rx_tick = 0;
  rx_mode_t    rx_mode = RX_OPEN;

  one_wire_rom_slave_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Clock with a period of 8 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit: a correct run finishes far inside this many cycles, so reaching it
  // means that the block has hung on one of its handshakes.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side. Each transaction that the block hands out is checked against the oldest
  // level set still due. The stall pattern switches at random between always ready, a
  // regular repeating pattern, a coin toss per cycle and short windows of readiness, so
  // that back-pressure lands on every phase of the protocol.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_levels(out_data);
    rx_tick++;
    if (rx_tick % 300 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:          out_ready <= 1'b1;
      RX_THREE_IN_FOUR: out_ready <= (rx_tick % 4) != 0;
      RX_COIN:          out_ready <= 1'($urandom_range(0, 1));
      default:          out_ready <= (rx_tick % 16) < 3;
    endcase
  end

  // Offers one input transaction and returns once it has been accepted. The sender
  // works in bursts; at the end of a burst valid is dropped for a random gap.
  task automatic send_item(input logic act, input logic lvl, input logic [TIME_W-1:0] at);
    int       gap;
    owrs_in_t item;
    item.action     = act;
    item.line_level = lvl;
    item.time_now   = at;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(item);
    sent_items++;
  endtask

  // Moves the stimulus clock forward, pinned at the top of the time range.
  task automatic advance(input longint unsigned ticks);
    logic [TIME_W:0] sum;
    sum   = {1'b0, stamp} + (TIME_W+1)'(ticks);
    stamp = sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
  endtask

  task automatic line_to(input logic lvl, input longint unsigned ticks);
    advance(ticks);
    send_item(ACT_LINE, lvl, stamp);
  endtask

  // The line level carried by a tick is ignored by the block, so it is left random.
  task automatic tick_at(input longint unsigned ticks);
    advance(ticks);
    send_item(ACT_TICK, 1'($urandom_range(0, 1)), stamp);
  endtask

  // Holds the input idle until every result still due has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // APB write: a setup cycle, then an access cycle that completes once pready is high.
  task automatic cfg_write(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  // One exchange as a master would run it: bus reset, presence, eight command bits sent
  // LSB first, then a number of read slots. Each deadline is met on the exact tick, the reset
  // up to two ticks late, and a read past the last ROM byte checks that the slave stays released.
  task automatic rom_session(input logic [7:0] cmd, input int read_bits);
    int unsigned sample_ticks;
    int unsigned release_ticks;
    int unsigned low_ticks;
    int unsigned pres_ticks;
    int unsigned part;
    sample_ticks  = tracker.cfg.sample_delay;
    release_ticks = tracker.cfg.read_release_delay;
    low_ticks     = tracker.cfg.reset_low_time;
    pres_ticks    = tracker.cfg.presence_length;
    line_to(1'b1, $urandom_range(0, 3));
    line_to(1'b0, $urandom_range(1, 5));
    // Sometimes tick part of the way through the low time first; no reset yet.
    part = ($urandom_range(0, 3) == 0) ? $urandom_range(0, low_ticks - 1) : 0;
    if (part != 0) tick_at(part);
    tick_at(low_ticks - part + $urandom_range(0, 2));
    line_to(1'b1, $urandom_range(1, 4));
    tick_at(tracker.cfg.presence_wait);
    part = $urandom_range(0, pres_ticks);
    if ($urandom_range(0, 2) == 0) tick_at(part);
    else part = 0;
    tick_at(pres_ticks - part);
    for (int i = 0; i < 8; i++) begin
      line_to(1'b0, $urandom_range(1, 4));
      if (cmd[i]) begin
        // A one: the master lets go before the sample point.
        part = (sample_ticks > 0) ? $urandom_range(0, sample_ticks - 1) : 0;
        line_to(1'b1, part);
        tick_at(sample_ticks - part);
      end else begin
        tick_at(sample_ticks);
        line_to(1'b1, $urandom_range(1, 3));
      end
    end
    for (int j = 0; j < read_bits; j++) begin
      line_to(1'b0, $urandom_range(1, 4));
      part = (release_ticks > 1) ? $urandom_range(1, release_ticks - 1) : 0;
      line_to(1'b1, part);
      tick_at(release_ticks - part);
    end
  endtask

  // Unstructured traffic: random kinds and levels, some times stepping backwards and
  // some anywhere in the whole time range.
  task automatic line_noise(input int count);
    logic [63:0] wide;
    repeat (count) begin
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: send_item(wide[63], wide[62], wide[TIME_W-1:0]);
        1: send_item(wide[63], wide[62], stamp - TIME_W'($urandom_range(0, 50)));
        default: begin
          advance($urandom_range(0, 2 * tracker.cfg.reset_low_time));
          send_item(wide[63], wide[62], stamp);
        end
      endcase
    end
  endtask

  // One setting of the registers, written while the block is quiet, followed by a run of
  // exchanges and noise. Every so often the sender waits for all results to come out.
  task automatic run_phase(input logic [ROM_W-1:0] rom,
                           input logic [DELAY_W-1:0] sample_ticks, release_ticks,
                           input logic [DELAY_W-1:0] low_ticks, wait_ticks, pres_ticks,
                           input bit near_top);
    int         first;
    int         pick;
    logic [7:0] cmd;
    drain();
    cfg_write(REG_ROM_ID, PDATA_W'(rom));
    cfg_write(REG_SAMPLE_DELAY, PDATA_W'(sample_ticks));
    cfg_write(REG_READ_RELEASE, PDATA_W'(release_ticks));
    cfg_write(REG_RESET_LOW, PDATA_W'(low_ticks));
    cfg_write(REG_PRESENCE_WAIT, PDATA_W'(wait_ticks));
    cfg_write(REG_PRESENCE_LEN, PDATA_W'(pres_ticks));
    if (near_top) stamp = TIME_TOP - TIME_W'($urandom_range(2000, 200000));
    else stamp = TIME_W'($urandom_range(0, 1000000));
    first = sent_items;
    while (sent_items - first < PHASE_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) cmd = CMD_READ_ROM;
        else if (pick < 7) cmd = CMD_READ_ROM_ALT;
        else cmd = 8'($urandom);
        rom_session(cmd, ($urandom_range(0, 4) == 0) ? 64 + $urandom_range(0, 3)
                                                     : $urandom_range(0, 20));
      end else begin
        line_noise($urandom_range(4, 20));
      end
      if ($urandom_range(0, 5) == 0) drain();
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    stamp      = '0;
    sent_items = 0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening with the reset timing. A tick at time zero with nothing armed, then
    // a repeated high and low that only store the master level, either side of a falling edge.
    send_item(ACT_TICK, 1'b0, 48'd0);
    send_item(ACT_LINE, 1'b1, 48'd0);
    send_item(ACT_LINE, 1'b0, 48'd5);
    send_item(ACT_LINE, 1'b0, 48'd6);
    // Early tick, then one with time stepping backwards: neither reaches the reset.
    send_item(ACT_TICK, 1'b1, 48'd900);
    send_item(ACT_TICK, 1'b0, 48'd500);
    // Reset, presence wait, presence pulse with the master pulling low during it.
    send_item(ACT_TICK, 1'b1, 48'd965);
    send_item(ACT_LINE, 1'b1, 48'd970);
    send_item(ACT_TICK, 1'b0, 48'd1030);
    send_item(ACT_LINE, 1'b0, 48'd1100);
    send_item(ACT_LINE, 1'b1, 48'd1110);
    send_item(ACT_TICK, 1'b1, 48'd1270);
    // First command bit, sampled as a zero.
    send_item(ACT_LINE, 1'b0, 48'd1300);
    send_item(ACT_TICK, 1'b0, 48'd1360);
    send_item(ACT_LINE, 1'b1, 48'd1365);
    // Near the top of the time range every deadline saturates, so the reset and the
    // sample come due together on the last tick value.
    send_item(ACT_LINE, 1'b0, TIME_TOP - 48'd10);
    send_item(ACT_TICK, 1'b1, TIME_TOP);
    send_item(ACT_LINE, 1'b1, TIME_TOP);
    send_item(ACT_TICK, 1'b0, TIME_TOP);
    send_item(ACT_TICK, 1'b1, TIME_TOP);
    // Time wraps back to zero, where nothing is armed; a new slot then samples its bit at 60.
    send_item(ACT_TICK, 1'b1, 48'd0);
    send_item(ACT_LINE, 1'b0, 48'd0);
    send_item(ACT_TICK, 1'b1, 48'd60);
    send_item(ACT_LINE, 1'b1, 48'd61);

    // Random part over several register settings: short timing, all maxima, all minima,
    // zero delays, and two random settings, one of them close to the top of time.
    run_phase({$urandom, $urandom}, 16'd3, 16'd2, 16'd20, 16'd4, 16'd6, 1'b0);
    run_phase('1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    run_phase('0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
    run_phase({$urandom, $urandom}, 16'd0, 16'd0, 16'd40, 16'd0, 16'd0, 1'b0);
    run_phase({$urandom, $urandom}, 16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
              16'($urandom_range(50, 240)), 16'($urandom_range(1, 50)),
              16'($urandom_range(1, 100)), 1'b1);
    // A write to an address beyond the map must not disturb the setting that follows.
    drain();
    cfg_write(REG_SPARE, {$urandom, $urandom});
    run_phase({$urandom, $urandom}, 16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)),
              16'($urandom_range(40, 120)), 16'($urandom_range(1, 30)),
              16'($urandom_range(1, 60)), 1'b0);

    // Let every result come out, then keep checking the output before the verdict, so that
    // any stray transaction would be caught.
    drain();
    repeat (8) @(posedge clk);
    if (tracker.fault_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: one_wire_rom_slave_top.f
hdl/owrs_pkg.sv
hdl/owrs_core.sv
hdl/owrs_skid.sv
hdl/one_wire_rom_slave_top.sv
bench/one_wire_rom_slave_top_tb.sv
